@@ sv/utf8_cjk_word_tokenizer_core_assert.svh @@
// Assertion macros shared by the tokenizer core
`ifndef UTF8_CJK_WORD_TOKENIZER_CORE_ASSERT_SVH
`define UTF8_CJK_WORD_TOKENIZER_CORE_ASSERT_SVH

// Check a consequence in the same cycle as its trigger
`define UTFCJK_ASSERT_NOW(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its trigger
`define UTFCJK_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/utfcjk_pkg.sv @@
`timescale 1ns / 1ps

package utfcjk_pkg;

	// UTF-8 byte class masks and codes
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_CODE  = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;

	// sequence lengths
	localparam logic [2:0] SEQ_LEN2 = 3'd2;
	localparam logic [2:0] SEQ_LEN3 = 3'd3;
	localparam logic [2:0] SEQ_LEN4 = 3'd4;

	// kept code point range
	localparam logic [15:0] CP_LO = 16'h4E00;
	localparam logic [15:0] CP_HI = 16'h9FFF;

	// result kinds
	localparam logic KIND_TOKEN = 1'b0;
	localparam logic KIND_END   = 1'b1;

	// tokenizer state carried between bytes
	typedef struct packed {
		logic [1:0] skip;
		logic [2:0] seq_len;
		logic [7:0] held0;
		logic [7:0] held1;
		logic       seq_ok;
		logic       in_word;
	} state_t;

	// results caused by one input word
	typedef struct packed {
		logic [1:0] tok_cnt;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       start0;
		logic       has_end;
	} grp_t;

	function automatic logic is_alnum(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h61 && b <= 8'h7A);
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return (b & CONT_MASK) == CONT_CODE;
	endfunction

endpackage

@@ sv/utfcjk_if.sv @@
`timescale 1ns / 1ps

// query byte channel
interface utfcjk_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       query_last;

	modport source (output valid, output in_byte, output query_last, input ready);
	modport sink (input valid, input in_byte, input query_last, output ready);
endinterface

// token result channel
interface utfcjk_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] out_byte;
	logic       token_start;
	logic       run_last;

	modport source (output valid, output kind, output out_byte, output token_start,
		output run_last, input ready);
	modport sink (input valid, input kind, input out_byte, input token_start,
		input run_last, output ready);
endinterface

@@ sv/utf8_cjk_word_tokenizer_core.sv @@
`timescale 1ns / 1ps
// The first result of a byte is offered in the cycle after the byte is taken.
// Throughput: one byte per cycle while bytes give at most one result and the receiver
// is ready; a byte with more results holds the input, as there is one result register.
// Reset: arst_n clears the decode state and drops any results not yet taken.

module utf8_cjk_word_tokenizer_core
	import utfcjk_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	utfcjk_in_if.sink   query,
	utfcjk_out_if.source tokens
);

`include "utf8_cjk_word_tokenizer_core_assert.svh"

	state_t state_q;
	state_t state_nxt;
	grp_t   grp;
	logic   free;
	logic   accept;

	assign query.ready = free;
	assign accept      = query.valid & free;

	// decode the incoming word against the held state
	utfcjk_decode u_decode (
		.cur        (state_q),
		.in_byte    (query.in_byte),
		.query_last (query.query_last),
		.nxt        (state_nxt),
		.grp        (grp)
	);

	// update the state on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// serialize the results of each word
	utfcjk_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.grp    (grp),
		.free   (free),
		.tokens (tokens)
	);

	`UTFCJK_ASSERT_NEXT(a_end_clears, clk, arst_n, accept && query.query_last,
		state_q == '0, "state not cleared after end of query")
	`UTFCJK_ASSERT_NOW(a_skip_len, clk, arst_n, state_q.skip != 2'd0,
		state_q.seq_len > 3'(state_q.skip), "sequence count exceeds length")
	`UTFCJK_ASSERT_NOW(a_no_word_in_seq, clk, arst_n, state_q.skip != 2'd0,
		!state_q.in_word, "word flag set inside a sequence")
	`UTFCJK_ASSERT_NOW(a_no_overrun, clk, arst_n, accept,
		!tokens.valid || (tokens.ready && tokens.run_last), "word taken while results pending")

endmodule

@@ sv/utfcjk_decode.sv @@
`timescale 1ns / 1ps

module utfcjk_decode
	import utfcjk_pkg::*;
(
	input  state_t     cur,
	input  logic [7:0] in_byte,
	input  logic       query_last,
	output state_t     nxt,
	output grp_t       grp
);

	logic [2:0]  pos;
	logic [1:0]  skip_dec;
	logic        ok_n;
	logic [7:0]  held1_n;
	logic [15:0] cp;

	always_comb begin
		nxt      = cur;
		grp      = '0;
		pos      = cur.seq_len - {1'b0, cur.skip};
		skip_dec = cur.skip - 2'd1;
		ok_n     = cur.seq_ok & is_cont(in_byte);
		held1_n  = (pos == 3'd1) ? in_byte : cur.held1;
		cp       = {cur.held0[3:0], held1_n[5:0], in_byte[5:0]};

		if (cur.skip != 2'd0) begin
			// consume a byte of an open sequence
			nxt.seq_ok = ok_n;
			nxt.held1  = held1_n;
			nxt.skip   = skip_dec;
			if (skip_dec == 2'd0) begin
				if (cur.seq_len == SEQ_LEN3 && ok_n && cp >= CP_LO && cp <= CP_HI) begin
					grp.tok_cnt = 2'd3;
					grp.b0      = cur.held0;
					grp.b1      = held1_n;
					grp.b2      = in_byte;
					grp.start0  = 1'b1;
				end
				nxt.seq_len = 3'd0;
				nxt.seq_ok  = 1'b0;
				nxt.held0   = 8'h00;
				nxt.held1   = 8'h00;
			end
			nxt.in_word = 1'b0;
		end else if (!in_byte[7]) begin
			// pass ASCII letters and digits, drop the rest
			if (is_alnum(in_byte)) begin
				grp.tok_cnt = 2'd1;
				grp.b0      = in_byte;
				grp.start0  = ~cur.in_word;
				nxt.in_word = 1'b1;
			end else begin
				nxt.in_word = 1'b0;
			end
		end else begin
			// open a sequence on a lead byte, skip anything else
			if ((in_byte & LEAD2_MASK) == LEAD2_CODE) begin
				nxt.seq_len = SEQ_LEN2;
				nxt.skip    = 2'd1;
			end else if ((in_byte & LEAD3_MASK) == LEAD3_CODE) begin
				nxt.seq_len = SEQ_LEN3;
				nxt.skip    = 2'd2;
			end else if ((in_byte & LEAD4_MASK) == LEAD4_CODE) begin
				nxt.seq_len = SEQ_LEN4;
				nxt.skip    = 2'd3;
			end
			if (((in_byte & LEAD2_MASK) == LEAD2_CODE) ||
				((in_byte & LEAD3_MASK) == LEAD3_CODE) ||
				((in_byte & LEAD4_MASK) == LEAD4_CODE)) begin
				nxt.held0  = in_byte;
				nxt.held1  = 8'h00;
				nxt.seq_ok = 1'b1;
			end
			nxt.in_word = 1'b0;
		end

		// close the query: marker after any tokens, clear state
		if (query_last) begin
			grp.has_end = 1'b1;
			nxt         = '0;
		end
	end

endmodule

@@ sv/utfcjk_emit.sv @@
`timescale 1ns / 1ps

module utfcjk_emit
	import utfcjk_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  grp_t         grp,
	output logic         free,
	utfcjk_out_if.source tokens
);

	grp_t       grp_s1;
	logic [2:0] cnt_s1;
	logic [1:0] idx_q;
	logic       busy_q;
	logic [2:0] cnt_in;
	logic       is_tok;
	logic       is_last;
	logic       take;

	assign cnt_in  = {1'b0, grp.tok_cnt} + {2'b00, grp.has_end};
	assign is_tok  = idx_q < grp_s1.tok_cnt;
	assign is_last = ({1'b0, idx_q} + 3'd1) == cnt_s1;
	assign take    = tokens.valid & tokens.ready;
	assign free    = ~busy_q | (take & is_last);

	// hold the result group of the last accepted word
	always_ff @(posedge clk) begin
		if (load) begin
			grp_s1 <= grp;
			cnt_s1 <= cnt_in;
		end
	end

	// advance through the group one result per handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (load) begin
			busy_q <= cnt_in != 3'd0;
			idx_q  <= 2'd0;
		end else if (take) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 2'd1;
		end
	end

	// select the current result
	always_comb begin
		tokens.valid       = busy_q;
		tokens.kind        = is_tok ? KIND_TOKEN : KIND_END;
		tokens.token_start = is_tok && idx_q == 2'd0 && grp_s1.start0;
		tokens.run_last    = is_last;
		case (idx_q)
			2'd0:    tokens.out_byte = grp_s1.b0;
			2'd1:    tokens.out_byte = grp_s1.b1;
			2'd2:    tokens.out_byte = grp_s1.b2;
			default: tokens.out_byte = 8'h00;
		endcase
		if (!is_tok) begin
			tokens.out_byte = 8'h00;
		end
	end

endmodule

@@ dv/utf8_cjk_word_tokenizer_core_tb.sv @@
`timescale 1ns / 1ps

module utf8_cjk_word_tokenizer_core_tb;
	import utfcjk_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_BYTES  = 275;
	localparam int LONG_HOLD     = 120;
	localparam int DRAIN_CYCLES  = 8;

	// one expected token result
	typedef struct {
		bit       kind;
		bit [7:0] data;
		bit       start;
		bit       run_last;
	} token_res_t;

	// tokenizer predictor and queue of expected token results
	class token_scoreboard;
		token_res_t token_q[$];
		token_res_t step_q[$];
		bit [1:0]   owed;
		bit [2:0]   seq_len;
		bit [7:0]   lead_b;
		bit [7:0]   cont_b;
		bit         conts_ok;
		bit         mid_word;
		int         errors;
		int         n_bytes;
		int         n_results;
		int         n_words;
		int         n_cjk;
		int         n_queries;

		function new();
			clear_state();
		endfunction

		function void clear_state();
			owed     = '0;
			seq_len  = '0;
			lead_b   = '0;
			cont_b   = '0;
			conts_ok = 1'b0;
			mid_word = 1'b0;
		endfunction

		function bit is_word_char(bit [7:0] b);
			return b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
		endfunction

		function void add_result(bit kind, bit [7:0] data, bit start);
			token_res_t r;
			r.kind     = kind;
			r.data     = data;
			r.start    = start;
			r.run_last = 1'b0;
			step_q.push_back(r);
		endfunction

		// advance the decode state by one query byte and queue its results
		function void note_byte(bit [7:0] b, bit last);
			token_res_t r;
			bit [15:0]  cp;
			bit [2:0]   pos;
			bit [2:0]   len;
			n_bytes++;
			step_q.delete();
			if (owed != 0) begin
				// inside a multibyte sequence: consume whatever arrives
				pos = seq_len - {1'b0, owed};
				if ((b & CONT_MASK) != CONT_CODE)
					conts_ok = 1'b0;
				if (pos == 3'd1)
					cont_b = b;
				owed = owed - 2'd1;
				if (owed == 0) begin
					if (seq_len == SEQ_LEN3 && conts_ok) begin
						cp = {lead_b[3:0], cont_b[5:0], b[5:0]};
						if (cp >= CP_LO && cp <= CP_HI) begin
							add_result(KIND_TOKEN, lead_b, 1'b1);
							add_result(KIND_TOKEN, cont_b, 1'b0);
							add_result(KIND_TOKEN, b, 1'b0);
							n_cjk++;
						end
					end
					seq_len  = '0;
					conts_ok = 1'b0;
					lead_b   = '0;
					cont_b   = '0;
				end
				mid_word = 1'b0;
			end else if (!b[7]) begin
				if (is_word_char(b)) begin
					add_result(KIND_TOKEN, b, !mid_word);
					if (!mid_word)
						n_words++;
					mid_word = 1'b1;
				end else begin
					mid_word = 1'b0;
				end
			end else begin
				// open a sequence on a lead byte, skip anything else
				len = '0;
				if ((b & LEAD2_MASK) == LEAD2_CODE)
					len = SEQ_LEN2;
				else if ((b & LEAD3_MASK) == LEAD3_CODE)
					len = SEQ_LEN3;
				else if ((b & LEAD4_MASK) == LEAD4_CODE)
					len = SEQ_LEN4;
				if (len != 0) begin
					seq_len  = len;
					owed     = 2'(len - 3'd1);
					lead_b   = b;
					cont_b   = '0;
					conts_ok = 1'b1;
				end
				mid_word = 1'b0;
			end
			if (last) begin
				add_result(KIND_END, 8'h00, 1'b0);
				clear_state();
				n_queries++;
			end
			foreach (step_q[i]) begin
				r = step_q[i];
				r.run_last = (i == step_q.size() - 1);
				token_q.push_back(r);
			end
		endfunction

		task report(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			errors++;
		endtask

		// compare one accepted result with the oldest expectation
		task check_result(bit kind, bit [7:0] data, bit start, bit run_last);
			token_res_t e;
			n_results++;
			if (token_q.size() == 0) begin
				report($sformatf("unexpected result kind=%0d byte=%02h start=%0d last=%0d",
					kind, data, start, run_last));
				return;
			end
			e = token_q.pop_front();
			if (kind != e.kind)
				report($sformatf("kind %0d, want %0d", kind, e.kind));
			if (data != e.data)
				report($sformatf("out_byte %02h, want %02h", data, e.data));
			if (start != e.start)
				report($sformatf("token_start %0d, want %0d (byte %02h)", start, e.start,
					e.data));
			if (run_last != e.run_last)
				report($sformatf("run_last %0d, want %0d (byte %02h)", run_last,
					e.run_last, e.data));
		endtask
	endclass

	logic clk;
	logic arst_n;

	utfcjk_in_if  query_if ();
	utfcjk_out_if tok_if ();

	utf8_cjk_word_tokenizer_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query_if),
		.tokens (tok_if)
	);

	token_scoreboard sb;
	bit [7:0]        qbuf[$];
	bit              in_calm;
	bit              out_calm;
	bit              long_hold_req;
	int              hold_left;
	int              cycles;
	int              sent;
	int              qn;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t ns: timeout, %0d results still expected", $time, sb.token_q.size());
			$display("utf8_cjk_word_tokenizer_core_tb: done, errors");
			$finish;
		end
	end

	// sample both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (tok_if.valid && tok_if.ready)
				sb.check_result(tok_if.kind, tok_if.out_byte, tok_if.token_start,
					tok_if.run_last);
			if (query_if.valid && query_if.ready)
				sb.note_byte(query_if.in_byte, query_if.query_last);
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// token receiver: random stalls plus one long hold on request
	initial begin
		int gap;
		tok_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				tok_if.ready <= 1'b0;
				hold_left--;
			end else if (out_calm) begin
				tok_if.ready <= 1'b1;
			end else begin
				gap = pick_gap();
				if (gap == 0) begin
					tok_if.ready <= 1'b1;
				end else begin
					tok_if.ready <= 1'b0;
					hold_left = gap - 1;
				end
			end
		end
	end

	// offer one query word and hold it until taken
	task send_byte(bit [7:0] b, bit last);
		int gap;
		gap = in_calm ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			query_if.valid <= 1'b0;
		end
		@(negedge clk);
		query_if.valid      <= 1'b1;
		query_if.in_byte    <= b;
		query_if.query_last <= last;
		@(posedge clk);
		while (!query_if.ready)
			@(posedge clk);
		sent++;
	endtask

	task send_query();
		foreach (qbuf[i])
			send_byte(qbuf[i], i == qbuf.size() - 1);
		qbuf.delete();
	endtask

	function automatic void add_cjk(bit [15:0] cp);
		qbuf.push_back({4'hE, cp[15:12]});
		qbuf.push_back({2'b10, cp[11:6]});
		qbuf.push_back({2'b10, cp[5:0]});
	endfunction

	function automatic void add_word();
		int n;
		int r;
		n = $urandom_range(1, 6);
		repeat (n) begin
			r = $urandom_range(0, 2);
			if (r == 0)
				qbuf.push_back(8'($urandom_range(8'h30, 8'h39)));
			else if (r == 1)
				qbuf.push_back(8'($urandom_range(8'h41, 8'h5A)));
			else
				qbuf.push_back(8'($urandom_range(8'h61, 8'h7A)));
		end
	endfunction

	function automatic void add_sep();
		bit [7:0] b;
		do
			b = 8'($urandom_range(0, 127));
		while (sb.is_word_char(b));
		qbuf.push_back(b);
	endfunction

	// malformed, out-of-range or skipped material
	function automatic void add_noise();
		int r;
		int bad;
		bit [15:0] cp;
		r = $urandom_range(0, 5);
		case (r)
			0: begin
				qbuf.push_back(8'($urandom));
			end
			1: begin
				// valid encoding, out of range (overlong and surrogates included)
				if ($urandom_range(0, 1))
					cp = 16'($urandom_range(0, 16'h4DFF));
				else
					cp = 16'($urandom_range(16'hA000, 16'hFFFF));
				add_cjk(cp);
			end
			2: begin
				qbuf.push_back(8'($urandom_range(8'hC0, 8'hDF)));
				qbuf.push_back(8'($urandom));
			end
			3: begin
				qbuf.push_back(8'($urandom_range(8'hF0, 8'hF7)));
				repeat (3)
					qbuf.push_back(8'($urandom));
			end
			4: begin
				// break one continuation of an in-range character
				cp = 16'($urandom_range(16'h4E00, 16'h9FFF));
				bad = $urandom_range(1, 2);
				qbuf.push_back({4'hE, cp[15:12]});
				qbuf.push_back(bad == 1 ? 8'($urandom_range(0, 8'h7F)) : {2'b10, cp[11:6]});
				qbuf.push_back(bad == 2 ? {2'b11, 6'($urandom)} : {2'b10, cp[5:0]});
			end
			default: begin
				if ($urandom_range(0, 1))
					qbuf.push_back(8'($urandom_range(8'h80, 8'hBF)));
				else
					qbuf.push_back(8'($urandom_range(8'hF8, 8'hFF)));
			end
		endcase
	endfunction

	// mostly well-formed text, some noise, now and then a truncated tail
	function automatic void build_query(int nseg);
		int r;
		repeat (nseg) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				add_word();
			else if (r < 65)
				add_cjk(16'($urandom_range(16'h4E00, 16'h9FFF)));
			else if (r < 82)
				add_sep();
			else
				add_noise();
		end
		if ($urandom_range(0, 9) == 0) begin
			if ($urandom_range(0, 1)) begin
				qbuf.push_back(8'($urandom_range(8'hE0, 8'hEF)));
				repeat ($urandom_range(0, 1))
					qbuf.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end else begin
				qbuf.push_back(8'($urandom_range(8'hF0, 8'hF7)));
				repeat ($urandom_range(0, 2))
					qbuf.push_back(8'($urandom));
			end
		end
	endfunction

	initial begin
		sb = new();
		arst_n              = 1'b0;
		query_if.valid      = 1'b0;
		query_if.in_byte    = 8'h00;
		query_if.query_last = 1'b0;
		in_calm             = 1'b0;
		out_calm            = 1'b0;
		long_hold_req       = 1'b0;
		hold_left           = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// words, separators, both range ends; query ends on a completed character
		qbuf = {8'h41, 8'h7A, 8'h30, 8'h39, 8'h5A, 8'h7F,
			8'hE4, 8'hB8, 8'h80, 8'hE9, 8'hBF, 8'hBF};
		send_query();
		// just below range, bad continuation with ASCII inside, 2- and 4-byte forms,
		// stray bytes, truncated tail
		qbuf = {8'hE4, 8'hB7, 8'hBF, 8'hE4, 8'h41, 8'h80, 8'hC3, 8'hA9,
			8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hFF, 8'hE4, 8'hB8};
		send_query();

		sent = 0;
		qn   = 0;
		while (sent < RANDOM_BYTES) begin
			in_calm  = ($urandom_range(0, 3) == 0);
			out_calm = ($urandom_range(0, 4) == 0);
			if (qn == 4) begin
				// stall the receiver while the sender keeps pushing
				in_calm       = 1'b1;
				out_calm      = 1'b0;
				long_hold_req = 1'b1;
				build_query(12);
			end else begin
				build_query($urandom_range(1, 10));
			end
			send_query();
			qn++;
		end
		@(negedge clk);
		query_if.valid <= 1'b0;
		out_calm = 1'b0;

		while (sb.token_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d query bytes in %0d queries; %0d results checked.",
			sb.n_bytes, sb.n_queries, sb.n_results);
		$display("Tokens seen: %0d ASCII words, %0d CJK characters; mismatches: %0d.",
			sb.n_words, sb.n_cjk, sb.errors);
		if (sb.errors == 0)
			$display("utf8_cjk_word_tokenizer_core_tb: done, clean");
		else
			$display("utf8_cjk_word_tokenizer_core_tb: done, errors");
		$finish;
	end

endmodule
